FILE: design/sbcp_pkg.sv
package sbcp_pkg;

  localparam int BufferBytes = 64;
  localparam int IdxW = $clog2(BufferBytes);
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_PARAM = 2'd1,
    KIND_RX    = 2'd2,
    KIND_TICK  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OUT_OVR   = 3'd1,
    ST_IN_OVR    = 3'd2,
    ST_TIMEOUT   = 3'd3,
    ST_CHECKSUM  = 3'd4,
    ST_ID_MISS   = 3'd5
  } status_e;

  localparam logic [7:0] SyncByte = 8'hFF;
  localparam logic [7:0] IdBroadcast = 8'hFE;
  localparam logic [7:0] InsPing = 8'h01;
  localparam logic [7:0] InsSyncWrite = 8'h83;

  typedef enum logic [1:0] {
    CFG_BASE_TIMEOUT = 2'd0,
    CFG_PER_BYTE     = 2'd1
  } cfg_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] target_id;
    logic [7:0] instruction;
    logic [7:0] param_count;
    logic [7:0] data_byte;
  } req_t;

endpackage

FILE: design/sbcp_front.sv
module sbcp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      kind_i,
  input  logic [7:0]      target_id_i,
  input  logic [7:0]      instruction_i,
  input  logic [7:0]      param_count_i,
  input  logic [7:0]      data_byte_i,
  output logic            q_valid_o,
  input  logic            q_ready_i,
  output sbcp_pkg::req_t  q_req_o
);
  import sbcp_pkg::*;

  req_t             mem_q [QDepth];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign in_ready_o = (cnt_q != 2'(QDepth));
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop = q_valid_o && q_ready_i;
  assign q_req_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= '{kind: kind_e'(kind_i), target_id: target_id_i,
                         instruction: instruction_i, param_count: param_count_i,
                         data_byte: data_byte_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: design/sbcp_back.sv
module sbcp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [0:0]      cfg_index_i,
  input  logic [15:0]     cfg_data_i,
  input  logic            q_valid_i,
  output logic            q_ready_o,
  input  sbcp_pkg::req_t  q_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            tx_valid_o,
  output logic [7:0]      tx_byte_o,
  output logic            drive_enable_o,
  output logic            rx_valid_o,
  output logic [7:0]      rx_byte_o,
  output logic            done_res_o,
  output logic [2:0]      status_o,
  output logic            last_o
);
  import sbcp_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_HDR   = 10'b0000000010,
    S_CSUM  = 10'b0000000100,
    S_DONE  = 10'b0000001000,
    S_SUM   = 10'b0000010000,
    S_CHK   = 10'b0000100000,
    S_PAY   = 10'b0001000000,
    S_EMIT  = 10'b0010000000,
    S_LEN   = 10'b0100000000,
    S_RDW   = 10'b1000000000
  } state_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SEND = 2'd1,
    PH_WAIT = 2'd2,
    PH_RECV = 2'd3
  } phase_e;

  state_e      state_q, ret_q;
  phase_e      phase_q;
  logic [15:0] base_q;
  logic [7:0]  perb_q;
  logic [7:0]  exp_id_q, ins_q, left_q, txsum_q;
  logic [IdxW:0] idx_q;
  logic [8:0]  full_q;
  logic [15:0] elapsed_q, deadline_q;
  logic [7:0]  buf_q [BufferBytes];
  logic [7:0]  rd_q;
  logic [IdxW:0] ptr_q;
  logic [2:0]  hcnt_q;
  logic [7:0]  rsum_q, id_got_q, plen_q, csum_got_q;
  logic [2:0]  fin_st_q;

  logic        ov_q;
  logic        o_tx_q, o_rx_q, o_done_q, o_last_q;
  logic [7:0]  o_tb_q, o_rb_q;
  logic [2:0]  o_st_q;

  logic        slot_free;
  assign slot_free = !ov_q || out_ready_i;
  assign out_valid_o = ov_q;
  assign tx_valid_o = o_tx_q;
  assign drive_enable_o = o_tx_q;
  assign tx_byte_o = o_tb_q;
  assign rx_valid_o = o_rx_q;
  assign rx_byte_o = o_rb_q;
  assign done_res_o = o_done_q;
  assign status_o = o_st_q;
  assign last_o = o_last_q;

  assign cfg_ready_o = 1'b1;
  assign q_ready_o = (state_q == S_IDLE) && slot_free;

  logic [7:0]  hdr_byte;
  logic        bcast_end;
  logic [IdxW:0] pay_end;
  logic [23:0] prod;
  logic [16:0] dl_sum;
  logic [IdxW:0] nidx;
  logic [16:0] el_inc;

  assign prod = {8'd0, plen_q} * {16'd0, perb_q};
  assign dl_sum = {1'b0, deadline_q} + prod[16:0];
  assign bcast_end = (ins_q == InsSyncWrite) ||
                     (exp_id_q == IdBroadcast && ins_q != InsPing);
  assign pay_end = (plen_q > 8'd1) ? ((9'd3 + 9'(plen_q) > 9'(BufferBytes)) ?
                   (IdxW+1)'(BufferBytes) : (IdxW+1)'(9'd3 + 9'(plen_q)))
                   : (IdxW+1)'(4);
  assign el_inc = {1'b0, elapsed_q} + 17'd1;
  assign nidx = (idx_q > (IdxW+1)'(1) || q_req_i.data_byte == SyncByte) ?
                (idx_q + (IdxW+1)'(1)) : idx_q;

  always_comb begin
    case (hcnt_q)
      3'd0, 3'd1: hdr_byte = SyncByte;
      3'd2:       hdr_byte = exp_id_q;
      3'd3:       hdr_byte = left_q + 8'd2;
      default:    hdr_byte = ins_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && q_valid_i && slot_free && q_req_i.kind == KIND_RX &&
        (phase_q == PH_WAIT || phase_q == PH_RECV) && !idx_q[IdxW]) begin
      buf_q[idx_q[IdxW-1:0]] <= q_req_i.data_byte;
    end
    rd_q <= buf_q[ptr_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q <= S_IDLE;
      phase_q <= PH_IDLE;
      base_q <= 16'd500;
      perb_q <= 8'd10;
      exp_id_q <= '0; ins_q <= '0; left_q <= '0; txsum_q <= '0;
      idx_q <= '0; full_q <= '0; elapsed_q <= '0; deadline_q <= '0;
      ptr_q <= '0; hcnt_q <= '0; rsum_q <= '0; id_got_q <= '0;
      plen_q <= '0; csum_got_q <= '0; fin_st_q <= '0;
      ov_q <= 1'b0;
      o_tx_q <= 1'b0; o_rx_q <= 1'b0; o_done_q <= 1'b0; o_last_q <= 1'b0;
      o_tb_q <= '0; o_rb_q <= '0; o_st_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == 1'(CFG_BASE_TIMEOUT)) base_q <= cfg_data_i;
        else perb_q <= cfg_data_i[7:0];
      end
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (q_valid_i && slot_free) begin
            case (q_req_i.kind)
              KIND_START: begin
                if (9'd6 + 9'(q_req_i.param_count) > 9'(BufferBytes)) begin
                  phase_q <= PH_IDLE;
                  ov_q <= 1'b1; o_tx_q <= 1'b0; o_tb_q <= '0; o_rx_q <= 1'b0;
                  o_rb_q <= '0; o_done_q <= 1'b1; o_st_q <= ST_OUT_OVR;
                  o_last_q <= 1'b1;
                end else begin
                  exp_id_q <= q_req_i.target_id;
                  ins_q <= q_req_i.instruction;
                  left_q <= q_req_i.param_count;
                  txsum_q <= q_req_i.target_id + q_req_i.param_count + 8'd2 +
                             q_req_i.instruction;
                  phase_q <= PH_SEND;
                  hcnt_q <= 3'd0;
                  state_q <= S_HDR;
                end
              end
              KIND_PARAM: begin
                if (phase_q == PH_SEND) begin
                  ov_q <= 1'b1; o_tx_q <= 1'b1; o_tb_q <= q_req_i.data_byte;
                  o_rx_q <= 1'b0; o_rb_q <= '0; o_done_q <= 1'b0;
                  o_st_q <= ST_OK;
                  txsum_q <= txsum_q + q_req_i.data_byte;
                  left_q <= left_q - 8'd1;
                  o_last_q <= (left_q != 8'd1);
                  if (left_q == 8'd1) state_q <= S_CSUM;
                end
              end
              KIND_RX: begin
                if (phase_q == PH_WAIT || phase_q == PH_RECV) begin
                  if (phase_q == PH_WAIT) begin
                    phase_q <= PH_RECV;
                    elapsed_q <= '0;
                    deadline_q <= base_q;
                  end
                  if ((phase_q == PH_WAIT) ? (base_q == 16'd0)
                      : (elapsed_q >= deadline_q)) begin
                    fin_st_q <= ST_TIMEOUT; state_q <= S_DONE;
                  end else if (idx_q[IdxW]) begin
                    fin_st_q <= ST_IN_OVR; state_q <= S_DONE;
                  end else begin
                    if (idx_q == (IdxW+1)'(2)) id_got_q <= q_req_i.data_byte;
                    if (idx_q == (IdxW+1)'(3)) plen_q <= q_req_i.data_byte;
                    idx_q <= nidx;
                    if (nidx == (IdxW+1)'(4) && idx_q == (IdxW+1)'(3))
                      state_q <= S_LEN;
                    else if (full_q != 9'd0 && 9'(nidx) == full_q) begin
                      ptr_q <= (IdxW+1)'(2); rsum_q <= '0;
                      state_q <= S_RDW; ret_q <= S_SUM;
                    end else if (nidx[IdxW]) begin
                      fin_st_q <= ST_IN_OVR; state_q <= S_DONE;
                    end
                  end
                end
              end
              default: begin
                if (phase_q == PH_RECV) begin
                  if (el_inc[15:0] != 16'd0 && elapsed_q != 16'hFFFF)
                    elapsed_q <= el_inc[15:0];
                  if (((elapsed_q == 16'hFFFF) ? elapsed_q : el_inc[15:0])
                      >= deadline_q) begin
                    phase_q <= PH_IDLE;
                    ov_q <= 1'b1; o_tx_q <= 1'b0; o_tb_q <= '0;
                    o_rx_q <= 1'b0; o_rb_q <= '0; o_done_q <= 1'b1;
                    o_st_q <= ST_TIMEOUT; o_last_q <= 1'b1;
                  end
                end
              end
            endcase
          end
        end
        S_LEN: begin
          deadline_q <= (dl_sum[16] || prod[23:17] != '0) ? 16'hFFFF : dl_sum[15:0];
          full_q <= 9'd4 + 9'(plen_q);
          if (plen_q == 8'd0) begin
            ptr_q <= (IdxW+1)'(2); rsum_q <= '0;
            state_q <= S_RDW; ret_q <= S_SUM;
          end else if (idx_q[IdxW]) begin
            fin_st_q <= ST_IN_OVR; state_q <= S_DONE;
          end else state_q <= S_IDLE;
        end
        S_HDR: begin
          if (slot_free) begin
            ov_q <= 1'b1; o_tx_q <= 1'b1; o_tb_q <= hdr_byte;
            o_rx_q <= 1'b0; o_rb_q <= '0; o_done_q <= 1'b0; o_st_q <= ST_OK;
            o_last_q <= (hcnt_q == 3'd4) && (left_q != 8'd0);
            hcnt_q <= hcnt_q + 3'd1;
            if (hcnt_q == 3'd4) state_q <= (left_q == 8'd0) ? S_CSUM : S_IDLE;
          end
        end
        S_CSUM: begin
          if (slot_free) begin
            ov_q <= 1'b1; o_tx_q <= 1'b1; o_tb_q <= ~txsum_q;
            o_rx_q <= 1'b0; o_rb_q <= '0; o_done_q <= 1'b0; o_st_q <= ST_OK;
            o_last_q <= !bcast_end;
            if (bcast_end) begin
              fin_st_q <= ST_OK; state_q <= S_DONE;
            end else begin
              phase_q <= PH_WAIT; idx_q <= '0; full_q <= '0;
              elapsed_q <= '0; deadline_q <= '0; state_q <= S_IDLE;
            end
          end
        end
        S_RDW: begin
          ptr_q <= ptr_q + (IdxW+1)'(1);
          state_q <= ret_q;
        end
        S_SUM: begin
          if (9'(ptr_q) == full_q) begin
            csum_got_q <= rd_q;
            state_q <= S_CHK;
          end else begin
            rsum_q <= rsum_q + rd_q;
            state_q <= S_RDW;
          end
        end
        S_CHK: begin
          if (csum_got_q != ~rsum_q) begin
            fin_st_q <= ST_CHECKSUM; state_q <= S_DONE;
          end else if (id_got_q != exp_id_q) begin
            fin_st_q <= ST_ID_MISS; state_q <= S_DONE;
          end else begin
            ptr_q <= (IdxW+1)'(4);
            state_q <= S_PAY;
          end
        end
        S_PAY: begin
          if (ptr_q == pay_end || plen_q < 8'd2) begin
            fin_st_q <= ST_OK; state_q <= S_DONE;
          end else state_q <= S_EMIT;
          ptr_q <= ptr_q;
        end
        S_EMIT: begin
          if (slot_free) begin
            ov_q <= 1'b1; o_tx_q <= 1'b0; o_tb_q <= '0;
            o_rx_q <= 1'b1; o_rb_q <= rd_q; o_done_q <= 1'b0; o_st_q <= ST_OK;
            o_last_q <= 1'b0;
            ptr_q <= ptr_q + (IdxW+1)'(1);
            state_q <= S_PAY;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            phase_q <= PH_IDLE;
            ov_q <= 1'b1; o_tx_q <= 1'b0; o_tb_q <= '0; o_rx_q <= 1'b0;
            o_rb_q <= '0; o_done_q <= 1'b1; o_st_q <= fin_st_q; o_last_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/servo_bus_checksum_packet_engine_unit.sv
// a request is registered in the two-entry queue before the engine takes it; a parameter
// byte or tick result is registered in the output slot as the engine takes it, and a start
// sends its header from the header state; a reply is checked by reading it back from the
// buffer via read-wait and sum states; payload goes out via payload and emit states
// throughput: one request a cycle while idle and results are taken; a start holds intake
// reset: asynchronous active low, timeouts back to 500 and 10 ticks, queue empty, block idle
module servo_bus_checksum_packet_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  target_id_i,
  input  logic [7:0]  instruction_i,
  input  logic [7:0]  param_count_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        drive_enable_o,
  output logic        rx_valid_o,
  output logic [7:0]  rx_byte_o,
  output logic        done_res_o,
  output logic [2:0]  status_o,
  output logic        last_o
);
  import sbcp_pkg::*;

  logic q_valid, q_ready;
  req_t q_req;

  sbcp_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i, .target_id_i,
    .instruction_i, .param_count_i, .data_byte_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_req_o(q_req)
  );

  sbcp_back u_back (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_req_i(q_req),
    .out_valid_o, .out_ready_i, .tx_valid_o, .tx_byte_o, .drive_enable_o,
    .rx_valid_o, .rx_byte_o, .done_res_o, .status_o, .last_o
  );

endmodule

FILE: design/sbcp_checker.sv
module sbcp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       tx_valid_o,
  input logic       drive_enable_o,
  input logic       rx_valid_o,
  input logic       done_res_o,
  input logic [2:0] status_o,
  input logic       last_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped");

  a_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> drive_enable_o == tx_valid_o)
    else $error("drive enable mismatch");

  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({tx_valid_o, rx_valid_o, done_res_o}))
    else $error("mixed result");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> last_o && status_o <= 3'd5)
    else $error("done without last");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> status_o == 3'd0)
    else $error("status without done");

endmodule

bind servo_bus_checksum_packet_engine_unit sbcp_checker u_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .tx_valid_o, .drive_enable_o,
  .rx_valid_o, .done_res_o, .status_o, .last_o
);

FILE: sim/tb_servo_bus_checksum_packet_engine_unit.sv
module tb_servo_bus_checksum_packet_engine_unit;
  import sbcp_pkg::*;

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhSend = 2'd1;
  localparam logic [1:0] PhWait = 2'd2;
  localparam logic [1:0] PhRecv = 2'd3;
  localparam int StallLimit = 3000;
  localparam int SettleCycles = 300;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       drive_enable;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       done_res;
    logic [2:0] status;
    logic       last;
  } bus_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  kind_i;
  logic [7:0]  target_id_i;
  logic [7:0]  instruction_i;
  logic [7:0]  param_count_i;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        tx_valid_o;
  logic [7:0]  tx_byte_o;
  logic        drive_enable_o;
  logic        rx_valid_o;
  logic [7:0]  rx_byte_o;
  logic        done_res_o;
  logic [2:0]  status_o;
  logic        last_o;

  servo_bus_checksum_packet_engine_unit dut (.*);

  // model of the engine
  logic [15:0] m_base;
  logic [7:0]  m_per;
  logic [1:0]  m_phase;
  logic [7:0]  m_id;
  logic [7:0]  m_ins;
  logic [7:0]  m_left;
  logic [7:0]  m_tsum;
  logic [7:0]  m_idx;
  logic [8:0]  m_full;
  logic [7:0]  m_buf [BufferBytes];
  logic [15:0] m_elapsed;
  logic [15:0] m_deadline;

  bus_result_t due_results[$];
  req_t        pending_reqs[$];
  int          errors;
  bit          in_taken;
  bit          cfg_taken;
  int          send_gap;
  int          recv_gap;
  int          hold_cycles;
  bit          calm;
  int          quiet_cycles;

  task automatic push_result(logic txv, logic [7:0] txb, logic rxv, logic [7:0] rxb,
                             logic done, status_e st);
    bus_result_t r;
    r.tx_valid = txv;
    r.tx_byte = txb;
    r.drive_enable = txv;
    r.rx_valid = rxv;
    r.rx_byte = rxb;
    r.done_res = done;
    r.status = st;
    r.last = 1'b0;
    due_results.push_back(r);
  endtask

  task automatic end_txn(status_e st);
    m_phase = PhIdle;
    push_result(1'b0, 8'h00, 1'b0, 8'h00, 1'b1, st);
  endtask

  task automatic send_checksum();
    push_result(1'b1, ~m_tsum, 1'b0, 8'h00, 1'b0, ST_OK);
    if (m_ins == InsSyncWrite || (m_id == IdBroadcast && m_ins != InsPing)) begin
      end_txn(ST_OK);
    end else begin
      m_phase = PhWait;
      m_idx = 8'd0;
      m_full = 9'd0;
      m_elapsed = 16'd0;
      m_deadline = 16'd0;
    end
  endtask

  task automatic check_reply();
    logic [7:0] sum;
    int i;
    int plen;
    sum = 8'd0;
    plen = m_buf[3];
    for (i = 2; i + 1 < m_full && i < BufferBytes; i++) sum = sum + m_buf[i];
    if (m_buf[(m_full - 1) % BufferBytes] != ~sum) begin
      end_txn(ST_CHECKSUM);
    end else if (m_buf[2] != m_id) begin
      end_txn(ST_ID_MISS);
    end else begin
      for (i = 0; plen > 1 && i < plen - 1 && 4 + i < BufferBytes; i++)
        push_result(1'b0, 8'h00, 1'b1, m_buf[4 + i], 1'b0, ST_OK);
      end_txn(ST_OK);
    end
  endtask

  task automatic take_rx_byte(logic [7:0] b);
    int sum;
    if (m_phase == PhWait) begin
      m_phase = PhRecv;
      m_elapsed = 16'd0;
      m_deadline = m_base;
    end
    if (m_elapsed >= m_deadline) begin
      end_txn(ST_TIMEOUT);
    end else if (m_idx >= BufferBytes) begin
      end_txn(ST_IN_OVR);
    end else begin
      m_buf[m_idx] = b;
      if (m_idx > 1 || b == SyncByte) m_idx = m_idx + 8'd1;
      if (m_idx == 4) begin
        sum = m_deadline + m_buf[3] * m_per;
        m_deadline = (sum > 65535) ? 16'hFFFF : sum[15:0];
        m_full = 9'd4 + m_buf[3];
      end
      if (m_full != 0 && m_idx == m_full) check_reply();
      else if (m_idx >= BufferBytes) end_txn(ST_IN_OVR);
    end
  endtask

  task automatic engine_step(req_t q);
    int n0;
    logic [7:0] len;
    n0 = due_results.size();
    case (q.kind)
      KIND_START: begin
        if (6 + q.param_count > BufferBytes) begin
          end_txn(ST_OUT_OVR);
        end else begin
          len = q.param_count + 8'd2;
          m_id = q.target_id;
          m_ins = q.instruction;
          m_left = q.param_count;
          m_tsum = q.target_id + len + q.instruction;
          m_phase = PhSend;
          push_result(1'b1, SyncByte, 1'b0, 8'h00, 1'b0, ST_OK);
          push_result(1'b1, SyncByte, 1'b0, 8'h00, 1'b0, ST_OK);
          push_result(1'b1, q.target_id, 1'b0, 8'h00, 1'b0, ST_OK);
          push_result(1'b1, len, 1'b0, 8'h00, 1'b0, ST_OK);
          push_result(1'b1, q.instruction, 1'b0, 8'h00, 1'b0, ST_OK);
          if (q.param_count == 0) send_checksum();
        end
      end
      KIND_PARAM: begin
        if (m_phase == PhSend) begin
          push_result(1'b1, q.data_byte, 1'b0, 8'h00, 1'b0, ST_OK);
          m_tsum = m_tsum + q.data_byte;
          m_left = m_left - 8'd1;
          if (m_left == 0) send_checksum();
        end
      end
      KIND_RX: begin
        if (m_phase == PhWait || m_phase == PhRecv) take_rx_byte(q.data_byte);
      end
      default: begin
        if (m_phase == PhRecv) begin
          if (m_elapsed < 16'hFFFF) m_elapsed = m_elapsed + 16'd1;
          if (m_elapsed >= m_deadline) end_txn(ST_TIMEOUT);
        end
      end
    endcase
    if (due_results.size() > n0) due_results[due_results.size() - 1].last = 1'b1;
  endtask

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  // stimulus building
  task automatic add_req(kind_e k, logic [7:0] id, logic [7:0] ins, logic [7:0] cnt,
                         logic [7:0] b);
    req_t q;
    q.kind = k;
    q.target_id = id;
    q.instruction = ins;
    q.param_count = cnt;
    q.data_byte = b;
    pending_reqs.push_back(q);
  endtask

  task automatic add_rx(logic [7:0] b, int max_ticks);
    int t;
    add_req(KIND_RX, 8'($urandom), 8'($urandom), 8'($urandom), b);
    t = $urandom_range(0, max_ticks);
    repeat (t) add_req(KIND_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // one command with its reply; mode 0 clean, 1 possibly corrupted, 2 no reply
  task automatic add_txn(logic [7:0] id, logic [7:0] ins, logic [7:0] cnt, int rlen,
                         int mode, int ticks);
    logic [7:0] sum;
    logic [7:0] rid;
    logic [7:0] d;
    int i;
    add_req(KIND_START, id, ins, cnt, 8'($urandom));
    if (6 + cnt > BufferBytes) return;
    for (i = 0; i < cnt; i++)
      add_req(KIND_PARAM, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    if (ins == InsSyncWrite || (id == IdBroadcast && ins != InsPing) || mode == 2) return;
    if (mode == 1 && $urandom_range(0, 1)) begin
      add_rx(8'($urandom_range(0, 254)), ticks);
      add_rx(SyncByte, ticks);
      add_rx(8'($urandom_range(0, 254)), ticks);
    end
    rid = (mode == 1 && $urandom_range(0, 2) == 0) ? id ^ (8'd1 << $urandom_range(0, 7)) : id;
    add_rx(SyncByte, ticks);
    add_rx(SyncByte, ticks);
    add_rx(rid, ticks);
    add_rx(rlen[7:0], ticks);
    sum = rid + rlen[7:0];
    for (i = 0; i + 1 < rlen; i++) begin
      d = 8'($urandom);
      sum = sum + d;
      add_rx(d, ticks);
    end
    if (rlen > 0) add_rx((mode == 1 && $urandom_range(0, 1)) ? sum : ~sum, ticks);
  endtask

  task automatic add_random_txn(int ticks);
    logic [7:0] id;
    logic [7:0] ins;
    logic [7:0] cnt;
    int rlen;
    int sel;
    id = ($urandom_range(0, 5) == 0) ? IdBroadcast : 8'($urandom);
    sel = $urandom_range(0, 5);
    ins = (sel == 0) ? InsPing : (sel == 1) ? InsSyncWrite : 8'($urandom);
    sel = $urandom_range(0, 19);
    cnt = (sel == 0) ? 8'($urandom) : (sel == 1) ? 8'($urandom_range(50, 60)) :
          8'($urandom_range(0, 4));
    sel = $urandom_range(0, 19);
    rlen = (sel == 0) ? $urandom_range(55, 70) : $urandom_range(0, 6);
    sel = $urandom_range(0, 9);
    add_txn(id, ins, cnt, rlen, (sel < 6) ? 0 : (sel < 9) ? 1 : 2, ticks);
    if ($urandom_range(0, 7) == 0)
      add_req(kind_e'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
              8'($urandom_range(0, 8)), 8'($urandom));
  endtask

  task automatic write_cfg(cfg_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= 1'(idx);
    cfg_data_i <= val;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_taken = 1'b0;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0 && !in_valid_i && due_results.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic random_run(int n, int ticks);
    int start;
    start = pending_reqs.size();
    while (pending_reqs.size() - start < n) add_random_txn(ticks);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      in_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        {kind_i, target_id_i, instruction_i, param_count_i, data_byte_i} <=
          pending_reqs.pop_front();
        in_valid_i <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 6);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result ready
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) recv_gap = $urandom_range(1, 6);
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    bus_result_t w;
    req_t q;
    if (rst_ni) begin
      quiet_cycles++;
      if (out_valid_o && out_ready_i) begin
        quiet_cycles = 0;
        if (due_results.size() == 0) begin
          $display("unexpected result tx %0h rx %0h done %0b", tx_byte_o, rx_byte_o,
                   done_res_o);
          errors++;
        end else begin
          w = due_results.pop_front();
          if (tx_valid_o != w.tx_valid) report("tx_valid", tx_valid_o, w.tx_valid);
          if (tx_byte_o != w.tx_byte) report("tx_byte", tx_byte_o, w.tx_byte);
          if (drive_enable_o != w.drive_enable)
            report("drive_enable", drive_enable_o, w.drive_enable);
          if (rx_valid_o != w.rx_valid) report("rx_valid", rx_valid_o, w.rx_valid);
          if (rx_byte_o != w.rx_byte) report("rx_byte", rx_byte_o, w.rx_byte);
          if (done_res_o != w.done_res) report("done_res", done_res_o, w.done_res);
          if (status_o != w.status) report("status", status_o, w.status);
          if (last_o != w.last) report("last", last_o, w.last);
        end
      end
      if (in_valid_i && in_ready_o) begin
        quiet_cycles = 0;
        q.kind = kind_e'(kind_i);
        q.target_id = target_id_i;
        q.instruction = instruction_i;
        q.param_count = param_count_i;
        q.data_byte = data_byte_i;
        engine_step(q);
        in_taken = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        quiet_cycles = 0;
        if (cfg_index_i == 1'(CFG_BASE_TIMEOUT)) m_base = cfg_data_i;
        else m_per = cfg_data_i[7:0];
        cfg_taken = 1'b1;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("FAIL servo_bus_checksum_packet_engine_unit");
        $finish;
      end
    end
  end

  initial begin
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    kind_i = '0;
    target_id_i = '0;
    instruction_i = '0;
    param_count_i = '0;
    data_byte_i = '0;
    out_ready_i = 1'b0;
    errors = 0;
    in_taken = 1'b0;
    cfg_taken = 1'b0;
    send_gap = 0;
    recv_gap = 0;
    hold_cycles = 0;
    calm = 1'b0;
    quiet_cycles = 0;
    m_base = 16'd500;
    m_per = 8'd10;
    m_phase = PhIdle;
    m_id = '0;
    m_ins = '0;
    m_left = '0;
    m_tsum = '0;
    m_idx = '0;
    m_full = '0;
    m_elapsed = '0;
    m_deadline = '0;
    foreach (m_buf[i]) m_buf[i] = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: stray inputs, header extremes, broadcast ends, overrun
    add_req(KIND_PARAM, 8'h00, 8'h00, 8'h00, 8'hFF);
    add_req(KIND_RX, 8'hFF, 8'hFF, 8'hFF, 8'h00);
    add_req(KIND_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
    add_txn(8'h01, InsPing, 8'd0, 2, 0, 0);
    add_txn(8'hFF, 8'hFF, 8'd1, 0, 0, 0);
    add_txn(IdBroadcast, 8'h03, 8'd1, 0, 0, 0);
    add_txn(8'h05, InsSyncWrite, 8'd0, 0, 0, 0);
    add_req(KIND_START, 8'h07, 8'h02, 8'd59, 8'h00);
    add_req(KIND_START, 8'h07, 8'h02, 8'd255, 8'h00);
    add_req(KIND_START, 8'h00, 8'h02, 8'd2, 8'h00);
    add_req(KIND_START, 8'h00, 8'h02, 8'd0, 8'h00);
    add_rx(8'h00, 0);
    add_rx(SyncByte, 0);
    add_rx(8'h11, 0);
    add_rx(SyncByte, 0);
    add_rx(SyncByte, 0);
    add_rx(8'h00, 0);
    add_rx(8'h00, 0);
    drain();

    // long receiver hold while requests pile up
    hold_cycles = 400;
    random_run(35, 2);
    drain();

    write_cfg(CFG_BASE_TIMEOUT, 16'd0);
    write_cfg(CFG_PER_BYTE, 16'd0);
    add_txn(8'h09, InsPing, 8'd0, 2, 0, 0);
    random_run(10, 1);
    drain();

    write_cfg(CFG_BASE_TIMEOUT, 16'd4);
    write_cfg(CFG_PER_BYTE, 16'd1);
    random_run(20, 3);
    drain();

    write_cfg(CFG_BASE_TIMEOUT, 16'hFFFF);
    write_cfg(CFG_PER_BYTE, 16'hFF);
    random_run(15, 2);
    drain();

    write_cfg(CFG_BASE_TIMEOUT, 16'($urandom_range(0, 40)));
    write_cfg(CFG_PER_BYTE, 16'($urandom_range(0, 255)));
    calm = 1'b1;
    random_run(15, 3);
    drain();

    if (errors == 0) begin
      $display("PASS servo_bus_checksum_packet_engine_unit");
    end else begin
      $display("FAIL servo_bus_checksum_packet_engine_unit");
    end
    $finish;
  end

endmodule

FILE: servo_bus_checksum_packet_engine_unit.f
design/sbcp_pkg.sv
design/sbcp_front.sv
design/sbcp_back.sv
design/servo_bus_checksum_packet_engine_unit.sv
design/sbcp_checker.sv
sim/tb_servo_bus_checksum_packet_engine_unit.sv
